>>> rtl/rocfh_pkg.sv
// ----------------------------------------------------------------------------
// rocfh_pkg: shared constants for the rate-of-change fault hold block
// field widths, register indexes and the saturated rate value
// ----------------------------------------------------------------------------
package rocfh_pkg;

  localparam int DATA_W        = 32;  // signed q16.16 sample
  localparam int CFG_W         = 31;  // unsigned q15.16 registers
  localparam int CFG_IDX_W     = 2;
  localparam int HISTORY_DEPTH = 5;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RATE_LIMIT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCAN_PERIOD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_TIME   = 2'd2;

  // register reset values
  localparam logic [CFG_W-1:0] RATE_LIMIT_RST  = 31'd0;
  localparam logic [CFG_W-1:0] SCAN_PERIOD_RST = 31'd6554;
  localparam logic [CFG_W-1:0] HOLD_TIME_RST   = 31'd327680;

  localparam logic [CFG_W-1:0] RATE_MAX = {CFG_W{1'b1}};

endpackage

>>> rtl/rate_of_change_fault_hold.sv
// ----------------------------------------------------------------------------
// rate_of_change_fault_hold: rate-of-change alarm with off-delayed fault
// five-deep sample history, bit-serial rate divider, peak tracking and
// hold of the last good value while the fault output is set
// ----------------------------------------------------------------------------
// sequence: history differences, sum of magnitudes, divider set-up, the
// bit-serial divider giving one quotient bit a cycle (skipped when the rate
// saturates), limit compare, then off-delay timer and result load; one item
// in flight, and a stalled result holds the sequencer until it is taken
// reset: synchronous active-low rst_n clears history, timer, peak and held
// value and loads register defaults; fault_out reads 1 after reset
// ----------------------------------------------------------------------------
module rate_of_change_fault_hold (
  input  logic                               clk,
  input  logic                               rst_n,
  // input channel
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [rocfh_pkg::DATA_W-1:0] in_sample,
  input  logic                               in_external_fault,
  // result channel
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [rocfh_pkg::DATA_W-1:0] out_value_out,
  output logic                               out_fault_out,
  output logic [rocfh_pkg::CFG_W-1:0]         out_peak_rate,
  // configuration write port
  input  logic                               cfg_we,
  input  logic [rocfh_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rocfh_pkg::CFG_W-1:0]         cfg_data
);
  import rocfh_pkg::*;

  // sequencer states
  localparam logic [2:0] ST_IDLE = 3'd0;  // waiting for an input transfer
  localparam logic [2:0] ST_DIFF = 3'd1;  // the two history differences
  localparam logic [2:0] ST_SUM  = 3'd2;  // sum of magnitudes
  localparam logic [2:0] ST_LOAD = 3'd3;  // overflow check, divider set-up
  localparam logic [2:0] ST_DIV  = 3'd4;  // one quotient bit per cycle
  localparam logic [2:0] ST_FIN  = 3'd5;  // limit compare and peak update
  localparam logic [2:0] ST_OUT  = 3'd6;  // off-delay timer and result load

  localparam int QBITS = CFG_W;           // quotient bits produced serially
  localparam int CNT_W = $clog2(QBITS);

  // configuration registers
  logic [CFG_W-1:0] rate_limit_r,  rate_limit_nxt;
  logic [CFG_W-1:0] scan_period_r, scan_period_nxt;
  logic [CFG_W-1:0] hold_time_r,   hold_time_nxt;

  // block state
  logic [2:0]        state_r, state_nxt;
  logic [DATA_W-1:0] dl_r [HISTORY_DEPTH];
  logic [DATA_W-1:0] dl_nxt [HISTORY_DEPTH];
  logic [DATA_W-1:0] held_good_r, held_good_nxt;
  logic [DATA_W-1:0] elapsed_r,   elapsed_nxt;
  logic [CFG_W-1:0]  peak_r,      peak_nxt;
  logic              ext_r,       ext_nxt;
  logic              rate_fault_r, rate_fault_nxt;

  // datapath of the rate calculation
  logic signed [DATA_W:0] diff_a_r, diff_a_nxt;
  logic signed [DATA_W:0] diff_b_r, diff_b_nxt;
  logic [DATA_W+1:0]      sum_r,    sum_nxt;
  logic [CFG_W-1:0]       rem_r,    rem_nxt;   // partial remainder
  logic [QBITS-1:0]       nq_r,     nq_nxt;    // numerator bits out, quotient bits in
  logic                   sat_r,    sat_nxt;
  logic [CNT_W-1:0]       cnt_r,    cnt_nxt;

  // result register
  logic                     out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0]        value_r,     value_nxt;
  logic                     fault_r,     fault_nxt;
  logic [CFG_W-1:0]         peak_out_r,  peak_out_nxt;

  // combinational helpers
  logic [CFG_W-1:0]  per;          // scan period, zero taken as one
  logic [DATA_W:0]   mag_a, mag_b;
  logic [CFG_W+1:0]  trial;
  logic [CFG_W-1:0]  rate;
  logic [DATA_W:0]   tsum;
  logic              in_xfer, out_free, fault_now;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;

  assign out_valid     = out_valid_r;
  assign out_value_out = value_r;
  assign out_fault_out = fault_r;
  assign out_peak_rate = peak_out_r;

  assign per   = (scan_period_r == '0) ? CFG_W'(1) : scan_period_r;
  assign mag_a = diff_a_r[DATA_W] ? (DATA_W+1)'(0) - diff_a_r : diff_a_r;
  assign mag_b = diff_b_r[DATA_W] ? (DATA_W+1)'(0) - diff_b_r : diff_b_r;
  // trial subtract of the shifted remainder against the period
  assign trial = {1'b0, rem_r, nq_r[QBITS-1]} - {2'b00, per};
  assign rate  = sat_r ? RATE_MAX : nq_r;
  // timer advance, saturating at full scale
  assign tsum      = {1'b0, elapsed_r} + {2'b00, per};
  assign fault_now = rate_fault_r || ext_r;

  always_comb begin
    rate_limit_nxt  = rate_limit_r;
    scan_period_nxt = scan_period_r;
    hold_time_nxt   = hold_time_r;
    state_nxt       = state_r;
    dl_nxt          = dl_r;
    held_good_nxt   = held_good_r;
    elapsed_nxt     = elapsed_r;
    peak_nxt        = peak_r;
    ext_nxt         = ext_r;
    rate_fault_nxt  = rate_fault_r;
    diff_a_nxt      = diff_a_r;
    diff_b_nxt      = diff_b_r;
    sum_nxt         = sum_r;
    rem_nxt         = rem_r;
    nq_nxt          = nq_r;
    sat_nxt         = sat_r;
    cnt_nxt         = cnt_r;
    out_valid_nxt   = out_valid_r;
    value_nxt       = value_r;
    fault_nxt       = fault_r;
    peak_out_nxt    = peak_out_r;

    // register writes, expected only while no item is in work; unknown
    // indexes are ignored
    if (cfg_we) begin
      case (cfg_index)
        REG_RATE_LIMIT:  rate_limit_nxt  = cfg_data;
        REG_SCAN_PERIOD: scan_period_nxt = cfg_data;
        REG_HOLD_TIME:   hold_time_nxt   = cfg_data;
        default: ;
      endcase
    end

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          // newest sample at the head of the history
          for (int i = HISTORY_DEPTH - 1; i > 0; i--) begin
            dl_nxt[i] = dl_r[i-1];
          end
          dl_nxt[0] = in_sample;
          ext_nxt   = in_external_fault;
          state_nxt = ST_DIFF;
        end
      end
      ST_DIFF: begin
        diff_a_nxt = $signed({dl_r[2][DATA_W-1], dl_r[2]}) -
                     $signed({dl_r[0][DATA_W-1], dl_r[0]});
        diff_b_nxt = $signed({dl_r[3][DATA_W-1], dl_r[3]}) -
                     $signed({dl_r[1][DATA_W-1], dl_r[1]});
        state_nxt  = ST_SUM;
      end
      ST_SUM: begin
        sum_nxt   = {1'b0, mag_a} + {1'b0, mag_b};
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        // numerator is sum << 14; its top 17 bits seed the remainder, and
        // the quotient overflows 31 bits exactly when they reach the period
        rem_nxt = {14'd0, sum_r[DATA_W+1:17]};
        nq_nxt  = {sum_r[16:0], 14'd0};
        cnt_nxt = '0;
        if ({14'd0, sum_r[DATA_W+1:17]} >= per) begin
          sat_nxt   = 1'b1;
          state_nxt = ST_FIN;
        end else begin
          sat_nxt   = 1'b0;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (!trial[CFG_W+1]) begin
          rem_nxt = trial[CFG_W-1:0];
          nq_nxt  = {nq_r[QBITS-2:0], 1'b1};
        end else begin
          rem_nxt = {rem_r[CFG_W-2:0], nq_r[QBITS-1]};
          nq_nxt  = {nq_r[QBITS-2:0], 1'b0};
        end
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(QBITS - 1)) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        // a zero limit switches off the rate check and freezes the peak
        rate_fault_nxt = (rate_limit_r != '0) && (rate > rate_limit_r);
        if ((rate_limit_r != '0) && (rate > peak_r)) begin
          peak_nxt = rate;
        end
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          peak_out_nxt  = peak_r;
          if (fault_now) begin
            elapsed_nxt = '0;
            fault_nxt   = 1'b1;
          end else if (elapsed_r < {1'b0, hold_time_r}) begin
            elapsed_nxt = tsum[DATA_W] ? {DATA_W{1'b1}} : tsum[DATA_W-1:0];
            fault_nxt   = 1'b1;
          end else begin
            fault_nxt   = 1'b0;
          end
          // off-delay decides between live and held value
          if (fault_now || (elapsed_r < {1'b0, hold_time_r})) begin
            value_nxt = held_good_r;
          end else begin
            held_good_nxt = dl_r[HISTORY_DEPTH-1];
            value_nxt     = dl_r[0];
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_limit_r  <= RATE_LIMIT_RST;
      scan_period_r <= SCAN_PERIOD_RST;
      hold_time_r   <= HOLD_TIME_RST;
      state_r       <= ST_IDLE;
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
        dl_r[i] <= '0;
      end
      held_good_r   <= '0;
      elapsed_r     <= '0;
      peak_r        <= '0;
      out_valid_r   <= 1'b0;
      value_r       <= '0;
      fault_r       <= 1'b1;
      peak_out_r    <= '0;
    end else begin
      rate_limit_r  <= rate_limit_nxt;
      scan_period_r <= scan_period_nxt;
      hold_time_r   <= hold_time_nxt;
      state_r       <= state_nxt;
      dl_r          <= dl_nxt;
      held_good_r   <= held_good_nxt;
      elapsed_r     <= elapsed_nxt;
      peak_r        <= peak_nxt;
      out_valid_r   <= out_valid_nxt;
      value_r       <= value_nxt;
      fault_r       <= fault_nxt;
      peak_out_r    <= peak_out_nxt;
    end
  end

  // working registers of the rate datapath, no reset needed
  always_ff @(posedge clk) begin
    ext_r        <= ext_nxt;
    rate_fault_r <= rate_fault_nxt;
    diff_a_r     <= diff_a_nxt;
    diff_b_r     <= diff_b_nxt;
    sum_r        <= sum_nxt;
    rem_r        <= rem_nxt;
    nq_r         <= nq_nxt;
    sat_r        <= sat_nxt;
    cnt_r        <= cnt_nxt;
  end

endmodule

>>> rtl/rocfh_checker.sv
// ----------------------------------------------------------------------------
// rocfh_checker: port-level checks for the rate-of-change fault hold block
// watches the handshakes and the peak output over time
// ----------------------------------------------------------------------------
module rocfh_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic signed [rocfh_pkg::DATA_W-1:0] out_value_out,
  input logic                               out_fault_out,
  input logic [rocfh_pkg::CFG_W-1:0]         out_peak_rate
);
  import rocfh_pkg::*;

  // a stalled result holds still
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_value_out) &&
    $stable(out_fault_out) && $stable(out_peak_rate))
    else $error("result changed while stalled");

  // reset leaves no result pending
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

  // only one item in work at a time
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second input transfer while busy");

  // the peak never falls between resets
  a_peak_mono: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> out_peak_rate >= $past(out_peak_rate))
    else $error("peak rate decreased");

endmodule

bind rate_of_change_fault_hold rocfh_checker u_rocfh_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_value_out (out_value_out),
  .out_fault_out (out_fault_out),
  .out_peak_rate (out_peak_rate)
);

>>> tb/sv/rate_of_change_fault_hold_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rate_of_change_fault_hold_tb: self-checking bench for the rate alarm
// queued samples are driven through a bursty valid/ready sender, every
// result is checked against an in-bench model of the delay line, rate,
// peak, off-delay timer and held value, across several register settings
// ----------------------------------------------------------------------------
module rate_of_change_fault_hold_tb;
  import rocfh_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;  // cycles with no transfer at all
  localparam int SETTLE_CYCLES  = 40;    // settling pause, longer than the divider's work on one sample

  typedef struct packed {
    logic [DATA_W-1:0] sample;
    logic              ext;
  } scan_in_t;

  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic              fault;
    logic [CFG_W-1:0]  peak;
  } alarm_out_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic signed [DATA_W-1:0] in_sample = '0;
  logic                     in_external_fault = 1'b0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [DATA_W-1:0] out_value_out;
  logic                     out_fault_out;
  logic [CFG_W-1:0]         out_peak_rate;
  logic                     cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_index = REG_RATE_LIMIT;
  logic [CFG_W-1:0]         cfg_data = '0;

  rate_of_change_fault_hold DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_sample         (in_sample),
    .in_external_fault (in_external_fault),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_value_out     (out_value_out),
    .out_fault_out     (out_fault_out),
    .out_peak_rate     (out_peak_rate),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // alarm model: its own copy of the registers and of the block's state
  // --------------------------------------------------------------------------
  logic [CFG_W-1:0]  lim_q  = RATE_LIMIT_RST;
  logic [CFG_W-1:0]  per_q  = SCAN_PERIOD_RST;
  logic [CFG_W-1:0]  hold_q = HOLD_TIME_RST;
  logic [DATA_W-1:0] hist [HISTORY_DEPTH] = '{default: '0};
  logic [DATA_W-1:0] last_good    = '0;
  logic [31:0]       hold_elapsed = '0;
  logic [CFG_W-1:0]  peak_seen    = '0;

  scan_in_t   sample_backlog[$];   // samples waiting for the sender
  alarm_out_t alarm_expected[$];   // predicted results, oldest first

  int  mismatches = 0;
  logic steady_feed = 1'b0;        // set for phases sent without gaps

  // magnitude of a signed difference, at full precision
  function automatic logic [63:0] abs_gap(input logic [DATA_W-1:0] a,
                                          input logic [DATA_W-1:0] b);
    longint d;
    d = longint'($signed(a)) - longint'($signed(b));
    return (d < 0) ? -d : d;
  endfunction

  // one scan: shift, rate check, off-delay and held value
  function automatic alarm_out_t advance_alarm(input logic [DATA_W-1:0] smp,
                                               input logic ext);
    logic [63:0]      per;
    logic [63:0]      sum;
    logic [63:0]      quot;
    logic [63:0]      stretched;
    logic [CFG_W-1:0] rate;
    logic             rate_trip;
    logic             held;
    integer           k;
    alarm_out_t       r;
    // a zero scan period counts as one
    per = (per_q == '0) ? 64'd1 : 64'(per_q);
    for (k = HISTORY_DEPTH - 1; k > 0; k--) hist[k] = hist[k - 1];
    hist[0] = smp;
    rate_trip = 1'b0;
    // zero limit switches the rate check and the peak off
    if (lim_q != '0) begin
      sum  = abs_gap(hist[2], hist[0]) + abs_gap(hist[3], hist[1]);
      quot = (sum * 64'd16384) / per;
      rate = (quot > 64'(RATE_MAX)) ? RATE_MAX : quot[CFG_W-1:0];
      rate_trip = rate > lim_q;
      if (rate > peak_seen) peak_seen = rate;
    end
    if (rate_trip || ext) begin
      hold_elapsed = '0;
      held = 1'b1;
    end else if (hold_elapsed < hold_q) begin
      stretched = 64'(hold_elapsed) + per;
      hold_elapsed = (stretched > 64'hFFFF_FFFF) ? '1 : stretched[31:0];
      held = 1'b1;
    end else begin
      held = 1'b0;
    end
    if (held) begin
      r.value = last_good;
    end else begin
      last_good = hist[HISTORY_DEPTH - 1];
      r.value = smp;
    end
    r.fault = held;
    r.peak  = peak_seen;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // sender: bursts of random length, random gaps, prediction on each transfer
  // --------------------------------------------------------------------------
  int       gap_left = 0;
  int       burst_left = 1;
  scan_in_t next_scan;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left = 0;
      burst_left = 1;
    end else begin
      if (in_valid && in_ready)
        alarm_expected.push_back(advance_alarm(in_sample, in_external_fault));
      // slot is free once the current item has gone or none was offered
      if (!in_valid || in_ready) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (sample_backlog.size() != 0) begin
          next_scan = sample_backlog.pop_front();
          in_valid          <= 1'b1;
          in_sample         <= next_scan.sample;
          in_external_fault <= next_scan.ext;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 12);
            // mostly short gaps, sometimes long enough to land anywhere
            // in the divider's work
            if (steady_feed)
              gap_left = 0;
            else if ($urandom_range(0, 3) == 0)
              gap_left = $urandom_range(0, 45);
            else
              gap_left = $urandom_range(0, 2);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // receiver: stall pattern with its own modes, and the result check
  // --------------------------------------------------------------------------
  int         stall_left = 0;
  int         mode_left = 0;
  int         recv_mode = 0;
  alarm_out_t want;
  alarm_out_t got;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left = 0;
      mode_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        got.value = out_value_out;
        got.fault = out_fault_out;
        got.peak  = out_peak_rate;
        if (alarm_expected.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: result transfer with nothing expected: value_out %h fault_out %b peak_rate %h",
                     $time, got.value, got.fault, got.peak);
          mismatches++;
        end else begin
          want = alarm_expected.pop_front();
          if (got !== want) begin
            if (mismatches < 10)
              $display("%0t: mismatch value_out %h/%h fault_out %b/%b peak_rate %h/%h (exp/act)",
                       $time, want.value, got.value, want.fault, got.fault,
                       want.peak, got.peak);
            mismatches++;
          end
        end
      end
      // mode 0 never stalls, 1 short frequent stalls, 2 long rare ones
      if (mode_left == 0) begin
        recv_mode = $urandom_range(0, 2);
        mode_left = $urandom_range(50, 600);
      end else begin
        mode_left--;
      end
      if (stall_left != 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        case (recv_mode)
          1: if ($urandom_range(0, 2) == 0) stall_left = $urandom_range(1, 3);
          2: if ($urandom_range(0, 7) == 0) stall_left = $urandom_range(10, 40);
          default: ;
        endcase
        out_ready <= (stall_left == 0);
      end
    end
  end

  // watchdog on cycles without any transfer
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  task automatic queue_sample(input logic [DATA_W-1:0] s, input logic e);
    scan_in_t it;
    it.sample = s;
    it.ext = e;
    sample_backlog.push_back(it);
  endtask

  // sender drained, every result in, then a settling pause
  task automatic wait_quiet(input int settle);
    do @(negedge clk);
    while (sample_backlog.size() != 0 || in_valid || alarm_expected.size() != 0);
    repeat (settle) @(negedge clk);
  endtask

  // registers are only touched with the block idle
  task automatic start_phase(input logic [CFG_W-1:0] lim,
                             input logic [CFG_W-1:0] per,
                             input logic [CFG_W-1:0] hold);
    wait_quiet(SETTLE_CYCLES);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_RATE_LIMIT;
    cfg_data  <= lim;
    lim_q = lim;
    @(posedge clk);
    cfg_index <= REG_SCAN_PERIOD;
    cfg_data  <= per;
    per_q = per;
    @(posedge clk);
    cfg_index <= REG_HOLD_TIME;
    cfg_data  <= hold;
    hold_q = hold;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // signed noise in [-m, m]
  function automatic longint jitter(input longint m);
    return longint'($urandom_range(0, 2 * m)) - m;
  endfunction

  initial begin : stimulus
    logic [CFG_W-1:0]  lim;
    logic [CFG_W-1:0]  per;
    logic [CFG_W-1:0]  hold;
    logic [DATA_W-1:0] smp;
    logic              e;
    longint            step;
    longint            typ;
    longint            span;
    longint            lvl;
    longint            slope;
    int                fault_run;
    int                style;
    int                r;
    int                ph;
    int                k;

    fault_run = 0;
    lvl = 0;
    slope = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // register defaults: rate check off, fault_out set from reset for the
    // whole hold time, extremes of the sample range
    queue_sample(32'h7FFF_FFFF, 1'b0);
    queue_sample(32'h8000_0000, 1'b0);
    queue_sample(32'h7FFF_FFFF, 1'b0);
    queue_sample(32'h8000_0000, 1'b0);
    queue_sample(32'h0000_0000, 1'b0);
    queue_sample(32'hFFFF_FFFF, 1'b1);
    queue_sample(32'h0000_0001, 1'b0);

    // zero scan period, tiny limit: a single step trips the rate check,
    // then the fault holds for three scans of one unit each
    start_phase(31'd1, 31'd0, 31'd3);
    for (k = 0; k < 4; k++) queue_sample(32'd0, 1'b0);
    queue_sample(32'd1, 1'b0);
    for (k = 0; k < 7; k++) queue_sample(32'd1, 1'b0);
    queue_sample(32'd1, 1'b1);

    // random phases: smooth ramps with steps and spikes, one phase of raw noise
    for (ph = 0; ph < 12; ph++) begin
      case ($urandom_range(0, 8))
        0:       per = 31'd1;
        1:       per = RATE_MAX;
        2:       per = 31'($urandom_range(1, 100));
        default: per = 31'($urandom_range(2000, 200000));
      endcase
      step = longint'(1) << $urandom_range(0, 20);
      step = step + $urandom_range(0, 32'(step));
      // rough rate of a plain ramp, so the limit sits near the signal
      typ = step * 65536 / longint'(per);
      case ($urandom_range(0, 6))
        0: lim = '0;
        1: lim = 31'd1;
        2: lim = RATE_MAX;
        default: begin
          span = typ * $urandom_range(1, 8) / 2;
          if (span < 1)
            lim = 31'd1;
          else if (span > longint'(RATE_MAX))
            lim = RATE_MAX;
          else
            lim = span[CFG_W-1:0];
        end
      endcase
      case ($urandom_range(0, 5))
        0: hold = '0;
        1: hold = RATE_MAX;
        default: begin
          span = longint'(per) * $urandom_range(0, 12);
          hold = (span > longint'(RATE_MAX)) ? RATE_MAX : span[CFG_W-1:0];
        end
      endcase
      if (ph == 1) begin
        per = RATE_MAX;
        hold = RATE_MAX;
      end
      style = (ph == 6) ? 2 : $urandom_range(0, 1);
      start_phase(lim, per, hold);
      steady_feed = ($urandom_range(0, 3) == 0);

      repeat ($urandom_range(80, 120)) begin
        r = $urandom_range(0, 99);
        if (style == 2 || r < 2) begin
          smp = $urandom;
          lvl = longint'($signed(smp));
        end else begin
          if (r < 6)
            slope = jitter(step);
          else if (r < ((style == 1) ? 16 : 8))
            lvl = lvl + jitter(step * $urandom_range(4, 40));
          lvl = lvl + slope + jitter(step / 4);
          if (lvl > 64'sh7FFF_FFFF)
            lvl = 64'sh7FFF_FFFF;
          else if (lvl < -64'sh8000_0000)
            lvl = -64'sh8000_0000;
          smp = lvl[DATA_W-1:0];
        end
        // upstream faults come in short runs
        if (fault_run > 0) begin
          e = 1'b1;
          fault_run--;
        end else if ($urandom_range(0, 39) == 0) begin
          e = 1'b1;
          fault_run = $urandom_range(0, 6);
        end else begin
          e = 1'b0;
        end
        queue_sample(smp, e);
      end
    end

    // largest limit, unit period, zero hold: full-scale swings never trip the
    // rate check, even where the rate saturates, and the fault drops at once
    start_phase(RATE_MAX, 31'd1, 31'd0);
    steady_feed = 1'b0;
    queue_sample(32'h7FFF_FFFF, 1'b0);
    queue_sample(32'h8000_0000, 1'b0);
    queue_sample(32'h7FFF_FFFF, 1'b0);
    queue_sample(32'h8000_0000, 1'b0);
    queue_sample(32'h7FFF_FFFF, 1'b1);
    queue_sample(32'h8000_0000, 1'b0);
    queue_sample(32'h7FFF_FFFF, 1'b0);

    wait_quiet(SETTLE_CYCLES);
    if (mismatches == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
